// ===== hdl/segment_pointer_translation_table_top_assert.svh =====
// Assertion macros for the segment pointer translation table.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_POINTER_TRANSLATION_TABLE_TOP_ASSERT_SVH
`define SEGMENT_POINTER_TRANSLATION_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spt_pkg.sv =====
// Shared types and constants of the segment pointer translation table.
// No dependencies.
package spt_pkg;

  localparam int unsigned SEG_BITS_DEF   = 2;
  localparam int unsigned VALUE_BITS_DEF = 28;

  // Odd marker held by unused table entries.
  localparam logic [31:0] NIL_INIT = 32'h7000_0001;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_CHECK    = 2'd1,
    OP_EXPAND   = 2'd2,
    OP_COMPRESS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_BAD_ID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // update table, load result register
  } ctrl_cmd_t;

endpackage

// ===== hdl/spt_in_if.sv =====
// Input channel: one operation word with valid/ready handshake.
// No dependencies.
interface spt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] operand_word;
  logic [3:0]  tag_bits;

  modport source (output valid, opcode, operand_word, tag_bits, input ready);
  modport sink   (input valid, opcode, operand_word, tag_bits, output ready);
endinterface

// ===== hdl/spt_out_if.sv =====
// Output channel: one result word with valid/ready handshake.
// No dependencies.
interface spt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_word;

  modport source (output valid, status, result_word, input ready);
  modport sink   (input valid, status, result_word, output ready);
endinterface

// ===== hdl/spt_ctrl.sv =====
// Controller FSM: sequences capture and commit, owns the output valid flag.
// Depends on spt_pkg.
module spt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spt_pkg::ctrl_cmd_t cmd_o
);
  import spt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // result slot free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/spt_dp.sv =====
// Datapath: segment table, parallel compare, result formation and registers.
// Depends on spt_pkg.
module spt_dp #(
  parameter int unsigned SEG_BITS   = spt_pkg::SEG_BITS_DEF,
  parameter int unsigned VALUE_BITS = spt_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spt_pkg::ctrl_cmd_t cmd_i,
  input  logic [1:0]         opcode_i,
  input  logic [31:0]        operand_word_i,
  input  logic [3:0]         tag_bits_i,
  output logic [1:0]         status_o,
  output logic [31:0]        result_word_o
);
  import spt_pkg::*;

  localparam int unsigned OffsBits = VALUE_BITS - SEG_BITS;
  localparam int unsigned NumSegs  = 1 << SEG_BITS;
  localparam int unsigned CntW     = SEG_BITS + 1;

  // captured operation
  logic [1:0]  op_q;
  logic [31:0] word_q;
  logic [3:0]  tag_q;

  logic [31:0]         bases_q [NumSegs];
  logic [CntW-1:0]     used_q;
  logic [1:0]          status_q, status_d;
  logic [31:0]         result_q, result_d;

  logic [31:0]         seg;
  logic [NumSegs-1:0]  match;
  logic                known;
  logic [SEG_BITS-1:0] first_idx;
  logic [SEG_BITS-1:0] exp_id;
  logic [31:0]         exp_base;
  logic                do_write;

  assign seg      = {word_q[31:OffsBits], {OffsBits{1'b0}}};
  assign exp_id   = word_q[VALUE_BITS-1:OffsBits];
  assign exp_base = bases_q[exp_id];

  always_comb begin
    for (int i = 0; i < NumSegs; i++) begin
      match[i] = (bases_q[i] == seg) && (CntW'(i) < used_q);
    end
  end

  assign known = |match;

  // lowest matching entry
  always_comb begin
    first_idx = '0;
    for (int i = NumSegs - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = SEG_BITS'(i);
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    result_d = '0;
    do_write = 1'b0;
    case (op_q)
      OP_REGISTER: begin
        if (!known) begin
          if (used_q == CntW'(NumSegs)) begin
            status_d = ST_FULL;
          end else begin
            do_write = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        if (!known) begin
          status_d = ST_UNKNOWN;
        end
      end
      OP_EXPAND: begin
        if (exp_base[0]) begin
          status_d = ST_BAD_ID;
        end else begin
          result_d = exp_base | {{(32 - OffsBits){1'b0}}, word_q[OffsBits-1:0]};
        end
      end
      OP_COMPRESS: begin
        if (!known) begin
          status_d = ST_UNKNOWN;
        end else begin
          result_d = 32'({tag_q, first_idx, word_q[OffsBits-1:0]});
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      word_q <= operand_word_i;
      tag_q  <= tag_bits_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  // Segments have their low bits cleared and so are even; the odd nil
  // marker can never collide, so unused entries keep their reset marker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSegs; i++) begin
        bases_q[i] <= (i == 0) ? 32'h0 : NIL_INIT;
      end
      used_q <= CntW'(1);
    end else if (cmd_i.commit && do_write) begin
      bases_q[used_q[SEG_BITS-1:0]] <= seg;
      used_q                        <= used_q + CntW'(1);
    end
  end

  assign status_o      = status_q;
  assign result_word_o = result_q;

endmodule

// ===== hdl/segment_pointer_translation_table_top.sv =====
// Segment pointer translation table, top level.
// The accepted word is captured, then the execute state commits the result word.
// Execute waits while an older result word is still held and not taken.
// A new word is taken only after the capture/execute FSM has returned to idle.
// Reset (async, active low): table entry 0 = 0, others = nil marker, one used.
`include "segment_pointer_translation_table_top_assert.svh"
module segment_pointer_translation_table_top #(
  parameter int unsigned SEG_BITS   = spt_pkg::SEG_BITS_DEF,
  parameter int unsigned VALUE_BITS = spt_pkg::VALUE_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  spt_in_if.sink    in_i,
  spt_out_if.source out_o
);
  import spt_pkg::*;

  ctrl_cmd_t cmd;

  // FSM: IDLE takes a word, EXEC commits once the result slot is free.
  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Table, 2^SEG_BITS parallel comparators and result registers.
  spt_dp #(
    .SEG_BITS   (SEG_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (in_i.opcode),
    .operand_word_i (in_i.operand_word),
    .tag_bits_i     (in_i.tag_bits),
    .status_o       (out_o.status),
    .result_word_o  (out_o.result_word)
  );

  // One word in flight: after an accept the input side closes for execute.
  `SPT_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready, "accepted while busy")
  // Error results carry a zero word.
  `SPT_ASSERT_NOW(a_err_zero, out_o.valid && (out_o.status != ST_OK), out_o.result_word == 32'h0, "nonzero result on error")
  // A fresh result only follows an execute cycle.
  `SPT_ASSERT_NOW(a_rise_after_exec, $rose(out_o.valid), $past(!in_i.ready), "result without execute")

endmodule

// ===== test/tb_segment_pointer_translation_table_top.sv =====
// Self-checking bench for segment_pointer_translation_table_top.
// Needs spt_pkg, spt_in_if, spt_out_if and the top level; runs a directed
// table, then random words, checked against the typed row results or an in-bench table predictor.
`timescale 1ns / 100ps
module tb_segment_pointer_translation_table_top;
  import spt_pkg::*;

  // Block geometry, taken from the package defaults the instance uses.
  localparam int unsigned SEG_BITS   = SEG_BITS_DEF;
  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int unsigned OFFS_BITS  = VALUE_BITS - SEG_BITS;
  localparam int unsigned NUM_SEGS   = 1 << SEG_BITS;
  localparam logic [31:0] OFFS_MASK  = (32'h1 << OFFS_BITS) - 32'h1;
  localparam logic [31:0] NIL_STEP   = 32'h1000_0000;

  localparam int RANDOM_WORDS = 1980;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;  // idle time at the end for stray result words
  localparam int REPORT_MAX   = 10;

  // One expected result word.
  typedef struct {
    status_e     status;
    logic [31:0] word;
  } tr_result_t;

  // One directed row. When 'typed' is set the expected result is the one
  // written here; otherwise it comes from the predictor.
  typedef struct packed {
    op_e         op;
    logic [31:0] operand;
    logic [3:0]  tag;
    logic        typed;
    status_e     status;
    logic [31:0] result;
  } row_t;

  // Directed table. Segments are the address with the low 26 bits cleared,
  // so with two id bits every multiple of 0x0400_0000 is a segment.
  localparam int NUM_ROWS = 22;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // fresh table: only entry 0 (base zero) is valid
    '{OP_EXPAND,   32'h0000_1234, 4'h0, 1'b1, ST_OK,      32'h0000_1234},
    '{OP_EXPAND,   32'h0400_0000, 4'h0, 1'b1, ST_BAD_ID,  32'h0000_0000},
    '{OP_EXPAND,   32'hFFFF_FFFF, 4'hF, 1'b1, ST_BAD_ID,  32'h0000_0000},
    '{OP_CHECK,    32'h0000_0000, 4'h0, 1'b1, ST_OK,      32'h0000_0000},
    '{OP_CHECK,    32'h03FF_FFFF, 4'hF, 1'b1, ST_OK,      32'h0000_0000},
    '{OP_CHECK,    32'hFFFF_FFFF, 4'h0, 1'b1, ST_UNKNOWN, 32'h0000_0000},
    '{OP_COMPRESS, 32'h03FF_FFFF, 4'hF, 1'b1, ST_OK,      32'hF3FF_FFFF},
    '{OP_COMPRESS, 32'h0400_0000, 4'h0, 1'b1, ST_UNKNOWN, 32'h0000_0000},
    // top segment, then the same segment again
    '{OP_REGISTER, 32'hFFFF_FFFF, 4'h0, 1'b1, ST_OK,      32'h0000_0000},
    '{OP_REGISTER, 32'hFC00_0001, 4'hF, 1'b1, ST_OK,      32'h0000_0000},
    '{OP_COMPRESS, 32'hFFFF_FFFF, 4'hF, 1'b1, ST_OK,      32'hF7FF_FFFF},
    // tag nibble above the value bits must be ignored by expand
    '{OP_EXPAND,   32'hF7FF_FFFF, 4'h0, 1'b1, ST_OK,      32'hFFFF_FFFF},
    '{OP_EXPAND,   32'h0400_0000, 4'h0, 1'b0, ST_OK,      32'h0000_0000},
    // segment next to the nil marker, then fill the table
    '{OP_REGISTER, 32'h7000_0000, 4'h0, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_REGISTER, 32'h1234_5678, 4'h5, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_REGISTER, 32'h0800_0000, 4'h0, 1'b1, ST_FULL,    32'h0000_0000},
    // known segment still registers fine on a full table
    '{OP_REGISTER, 32'h0000_0005, 4'h0, 1'b1, ST_OK,      32'h0000_0000},
    '{OP_CHECK,    32'h1000_0000, 4'h0, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_EXPAND,   32'h0C00_ABCD, 4'h7, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_COMPRESS, 32'h73FF_FFFF, 4'h0, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_EXPAND,   32'h0800_0000, 4'h0, 1'b0, ST_OK,      32'h0000_0000},
    '{OP_COMPRESS, 32'h0000_0000, 4'h0, 1'b1, ST_OK,      32'h0000_0000}
  };

  logic clk_i;
  logic rst_ni;

  spt_in_if  in_if ();
  spt_out_if out_if ();

  segment_pointer_translation_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor copy of the segment table.
  logic [31:0] seg_base [NUM_SEGS];
  int unsigned seg_used;
  logic [31:0] nil_mark;

  tr_result_t  due_q [$];     // results owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;  // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // First used entry holding this segment, or -1.
  function automatic int find_seg(logic [31:0] seg);
    for (int i = 0; i < seg_used; i++)
      if (seg_base[i] == seg) return i;
    return -1;
  endfunction

  // Apply one word to the predicted table and return the result it owes.
  function automatic tr_result_t translate(op_e op, logic [31:0] word, logic [3:0] tag);
    tr_result_t          r;
    logic [31:0]         seg;
    logic [31:0]         base;
    logic [SEG_BITS-1:0] id;
    int                  idx;
    r.status = ST_OK;
    r.word   = '0;
    seg = word & ~OFFS_MASK;
    idx = find_seg(seg);
    case (op)
      OP_REGISTER: begin
        if (idx < 0) begin
          if (seg_used >= NUM_SEGS) begin
            r.status = ST_FULL;
          end else begin
            seg_base[seg_used] = seg;
            seg_used++;
            // new base hit the nil marker: move the marker, refill free slots
            if (nil_mark == seg) begin
              for (int t = 0; t < 16; t++) begin
                nil_mark += NIL_STEP;
                if (find_seg(nil_mark) < 0) break;
              end
              for (int i = seg_used; i < NUM_SEGS; i++) seg_base[i] = nil_mark;
            end
          end
        end
      end
      OP_CHECK: begin
        if (idx < 0) r.status = ST_UNKNOWN;
      end
      OP_EXPAND: begin
        id   = word[OFFS_BITS +: SEG_BITS];
        base = seg_base[id];
        if (base[0]) r.status = ST_BAD_ID;
        else r.word = base | (word & OFFS_MASK);
      end
      OP_COMPRESS: begin
        if (idx < 0) r.status = ST_UNKNOWN;
        else r.word = (32'(tag) << VALUE_BITS) | (32'(idx) << OFFS_BITS) | (word & OFFS_MASK);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word, wait for the handshake, then log what it should return.
  // Leaves the caller right after the accepting edge.
  task automatic send_word(input op_e op, input logic [31:0] word, input logic [3:0] tag,
                           input logic typed, input status_e st, input logic [31:0] res);
    tr_result_t want;
    int         gap;
    gap = (!quiet && $urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.operand_word <= word;
    in_if.tag_bits     <= tag;
    do @(posedge clk_i); while (!in_if.ready);
    want = translate(op, word, tag);
    if (typed) begin
      want.status = st;
      want.word   = res;
    end
    due_q.push_back(want);
  endtask

  // Result side: random backpressure, ~15% of cycles.
  always @(posedge clk_i) begin
    out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // Compare each accepted result word with the oldest one owed.
  always @(posedge clk_i) begin
    tr_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result word with none owed: status %0d word %h",
                   $realtime, out_if.status, out_if.result_word);
      end else begin
        want = due_q.pop_front();
        if (out_if.status !== want.status || out_if.result_word !== want.word) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch: status exp %0d got %0d, word exp %h got %h",
                     $realtime, want.status, out_if.status, want.word,
                     out_if.result_word);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    op_e         op;
    logic [31:0] word;
    logic [3:0]  tag;

    // known values on every block input from time zero
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = '0;
    in_if.operand_word = '0;
    in_if.tag_bits     = '0;
    out_if.ready       = 1'b0;

    // predicted reset state: base zero in entry 0, nil marker elsewhere
    foreach (seg_base[i]) seg_base[i] = NIL_INIT;
    seg_base[0] = '0;
    seg_used    = 1;
    nil_mark    = NIL_INIT;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++)
      send_word(DIRECTED[r].op, DIRECTED[r].operand, DIRECTED[r].tag,
                DIRECTED[r].typed, DIRECTED[r].status, DIRECTED[r].result);

    // random words; most addresses land in a known segment so compress and
    // check mostly hit, the rest probe unknown segments
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 600 && n < 1000);
      if (n == 1200) begin
        // hold off until the block has returned everything it owes
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (due_q.size() != 0);
      end
      op   = op_e'($urandom_range(3));
      tag  = 4'($urandom_range(15));
      word = $urandom;
      if (op != OP_EXPAND && $urandom_range(99) < 70)
        word = seg_base[$urandom_range(seg_used - 1)] | (word & OFFS_MASK);
      // push some offsets to their extremes
      case ($urandom_range(9))
        0: word = word & ~OFFS_MASK;
        1: word = word | OFFS_MASK;
        default: ;
      endcase
      send_word(op, word, tag, 1'b0, ST_OK, '0);
    end
    quiet = 1'b0;

    // drain: everything owed, then a few cycles for stray words
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
